// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and the elaboration-time root table builder for the
// breakpoint curve evaluator.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int unsigned MAX_POINTS_DEF = 64;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef struct packed {
		logic [31:0]        pos;
		logic [16:0]        lev;
		logic signed [15:0] bend;
		logic               hold;
	} bbc_point_t;

	// word travelling down the cell row
	typedef struct packed {
		logic        valid;
		logic        lock;
		logic        seg;
		logic [31:0] q;
		logic [16:0] lvl;
		bbc_point_t  lpt;
		bbc_point_t  rpt;
	} bbc_tok_t;

	typedef struct packed {
		logic first;
		logic inr;
		logic last;
		logic wr_en;
	} bbc_cell_ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-j) in Q2.30 by repeated square roots of 2.0
	function automatic logic [31:0] exp2_root(input int j);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) begin
			if (k <= j) r = isqrt64(r << 30);
		end
		return r[31:0];
	endfunction

endpackage

// ===== rtl/bbc_req_if.sv =====
// ----------------------------------------------------------------------------
// bbc_req_if
// Request channel: breakpoint writes and evaluate words.
// ----------------------------------------------------------------------------
interface bbc_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [5:0]         point_index;
	logic [31:0]        point_position;
	logic [16:0]        point_level;
	logic signed [15:0] point_bend;
	logic               point_hold;
	logic [31:0]        query_position;

	modport source (output valid, cmd, point_index, point_position, point_level,
		point_bend, point_hold, query_position, input ready);
	modport sink (input valid, cmd, point_index, point_position, point_level,
		point_bend, point_hold, query_position, output ready);
endinterface

// ===== rtl/bbc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bbc_rsp_if
// Result channel: one curve value per evaluate word.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] curve_value;

	modport source (output valid, curve_value, input ready);
	modport sink (input valid, curve_value, output ready);
endinterface

// ===== rtl/bbc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bbc_cfg_if
// Configuration write channel for the point count register.
// ----------------------------------------------------------------------------
interface bbc_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] point_count;

	modport source (output valid, point_count, input ready);
	modport sink (input valid, point_count, output ready);
endinterface

// ===== rtl/bbc_cell.sv =====
// ----------------------------------------------------------------------------
// bbc_cell
// One table slot: holds a breakpoint and checks the passing query word
// against it, capturing the segment or an end level.
// ----------------------------------------------------------------------------
module bbc_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bbc_pkg::bbc_cell_ctl_t ctl,
	input  bbc_pkg::bbc_point_t    wr_pt,
	input  bbc_pkg::bbc_point_t    prev_pt,
	output bbc_pkg::bbc_point_t    pt,
	input  bbc_pkg::bbc_tok_t      tok_in,
	output bbc_pkg::bbc_tok_t      tok_out
);

	bbc_pkg::bbc_point_t pt_q;
	bbc_pkg::bbc_tok_t   tok_q;
	bbc_pkg::bbc_tok_t   tok_n;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) pt_q <= wr_pt;
	end

	always_comb begin
		tok_n = tok_in;
		if (tok_in.valid && !tok_in.lock) begin
			if (ctl.first && ctl.inr && tok_in.q <= pt_q.pos) begin
				tok_n.lvl  = pt_q.lev;
				tok_n.lock = 1'b1;
			end else begin
				if (!ctl.first && ctl.inr && !tok_in.seg && tok_in.q <= pt_q.pos) begin
					tok_n.seg = 1'b1;
					tok_n.lpt = prev_pt;
					tok_n.rpt = pt_q;
				end
				// last point wins when the query is at or past it, or no segment hit
				if (ctl.last && (tok_in.q >= pt_q.pos || !tok_n.seg)) begin
					tok_n.seg  = 1'b0;
					tok_n.lvl  = pt_q.lev;
					tok_n.lock = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_n;
		end
	end

	assign pt      = pt_q;
	assign tok_out = tok_q;

endmodule

// ===== rtl/bbc_eval.sv =====
// ----------------------------------------------------------------------------
// bbc_eval
// Segment sequencer: divides for the fraction, bends it through log2/exp2
// and interpolates the two levels, one step per cycle.
// ----------------------------------------------------------------------------
module bbc_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  bbc_pkg::bbc_tok_t tok,
	input  logic              out_free,
	output logic              done,
	output logic [16:0]       value
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_BEND, ST_LOG, ST_EXP, ST_EXP_FIN, ST_PMUL, ST_LERP, ST_DONE
	} state_t;

	localparam logic signed [39:0] Y_MAX = 40'sd917504;
	localparam logic signed [39:0] Y_MIN = -40'sd4194304;

	localparam logic [31:0] RootTbl [0:15] = '{
		bbc_pkg::exp2_root(1),  bbc_pkg::exp2_root(2),  bbc_pkg::exp2_root(3),
		bbc_pkg::exp2_root(4),  bbc_pkg::exp2_root(5),  bbc_pkg::exp2_root(6),
		bbc_pkg::exp2_root(7),  bbc_pkg::exp2_root(8),  bbc_pkg::exp2_root(9),
		bbc_pkg::exp2_root(10), bbc_pkg::exp2_root(11), bbc_pkg::exp2_root(12),
		bbc_pkg::exp2_root(13), bbc_pkg::exp2_root(14), bbc_pkg::exp2_root(15),
		bbc_pkg::exp2_root(16)
	};

	state_t              state_q;
	bbc_pkg::bbc_tok_t   cur_q;
	logic [31:0]         span_q;
	logic [31:0]         rem_q;
	logic [16:0]         t_q;
	logic [3:0]          cnt_q;
	logic [30:0]         m_q;
	logic [15:0]         frac_q;
	logic [4:0]          k_q;
	logic [31:0]         e_q;
	logic [31:0]         acc_q;
	logic [15:0]         f_q;
	logic signed [8:0]   ip_q;
	logic                zero_q;
	logic                phase_q;
	logic [16:0]         value_q;

	// divide step
	logic [32:0] r2;
	logic        r2_ge;
	logic [31:0] diff0;
	logic [31:0] span0;
	// log step
	logic [4:0]  lead;
	logic [61:0] sq;
	logic [31:0] sq_sh;
	// exp step and finish
	logic [63:0] eprod;
	logic [63:0] eround;
	logic signed [9:0] s_full;
	logic [6:0]  s7;
	logic [63:0] shr;
	logic [31:0] exp_res;
	logic signed [39:0] exp_y;
	logic signed [39:0] exp_yc;
	// bend product
	logic [20:0] mag_w;
	logic [52:0] pm;
	logic [36:0] p_w;
	// interpolation
	logic        up;
	logic [16:0] dm;
	logic [33:0] lp;
	logic [33:0] inc;

	always_comb begin
		diff0 = tok.q - tok.lpt.pos;
		span0 = tok.rpt.pos - tok.lpt.pos;
		r2    = {rem_q, 1'b0};
		r2_ge = r2 >= {1'b0, span_q};

		lead = 5'd0;
		for (int i = 1; i <= 16; i++) begin
			if (t_q[i]) lead = 5'(i);
		end
		sq    = 62'(m_q) * 62'(m_q);
		sq_sh = sq[61:30];

		eprod  = 64'(acc_q) * 64'(RootTbl[cnt_q]);
		eround = eprod + (64'd1 << 29);
		s_full = 10'sd14 - 10'(ip_q);
		s7     = s_full[6:0];
		shr    = ({32'd0, acc_q} + (64'd1 << (s7 - 7'd1))) >> s7;
		if (zero_q || s7 > 7'd40) exp_res = '0;
		else if (s7 == 7'd0)      exp_res = acc_q;
		else                      exp_res = shr[31:0];

		mag_w = {5'(5'd16 - k_q), 16'h0} - {5'd0, frac_q};
		pm    = 53'(mag_w) * 53'(e_q);
		p_w   = 37'((pm + 53'd32768) >> 16);
		if (state_q == ST_LOG) exp_y = -(40'(cur_q.lpt.bend) <<< 2);
		else                   exp_y = -$signed({3'd0, p_w});
		exp_yc = (exp_y > Y_MAX) ? Y_MAX : exp_y;

		up  = cur_q.rpt.lev >= cur_q.lpt.lev;
		dm  = up ? cur_q.rpt.lev - cur_q.lpt.lev : cur_q.lpt.lev - cur_q.rpt.lev;
		lp  = 34'(dm) * 34'(t_q);
		inc = (lp + 34'd32768) >> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tok.valid) begin
						cur_q <= tok;
						if (!tok.seg) begin
							value_q <= tok.lvl;
							state_q <= ST_DONE;
						end else if (tok.rpt.pos <= tok.lpt.pos) begin
							value_q <= tok.rpt.lev;
							state_q <= ST_DONE;
						end else if (tok.lpt.hold) begin
							value_q <= tok.lpt.lev;
							state_q <= ST_DONE;
						end else begin
							span_q  <= span0;
							rem_q   <= (diff0 >= span0) ? diff0 - span0 : diff0;
							t_q     <= 17'(diff0 >= span0);
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= r2_ge ? 32'(r2 - {1'b0, span_q}) : r2[31:0];
					t_q   <= {t_q[15:0], r2_ge};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= ST_BEND;
				end
				ST_BEND: begin
					if (cur_q.lpt.bend == 16'sd0) begin
						state_q <= ST_LERP;
					end else begin
						k_q     <= lead;
						m_q     <= 31'({14'd0, t_q} << (5'd30 - lead));
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					m_q    <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
					frac_q <= {frac_q[14:0], sq_sh[31]};
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						// start exp2(-4*bend) for the exponent
						phase_q <= 1'b0;
						zero_q  <= exp_y < Y_MIN;
						ip_q    <= 9'(exp_yc >>> 16);
						f_q     <= exp_yc[15:0];
						acc_q   <= 32'd1 << 30;
						state_q <= (exp_y < Y_MIN) ? ST_EXP_FIN : ST_EXP;
					end
				end
				ST_EXP: begin
					if (f_q[4'd15 - cnt_q]) acc_q <= eround[61:30];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= ST_EXP_FIN;
				end
				ST_EXP_FIN: begin
					cnt_q <= '0;
					if (!phase_q) begin
						e_q     <= exp_res;
						state_q <= ST_PMUL;
					end else begin
						t_q     <= (exp_res > 32'(bbc_pkg::ONE_Q16)) ? bbc_pkg::ONE_Q16
							: exp_res[16:0];
						state_q <= ST_LERP;
					end
				end
				ST_PMUL: begin
					phase_q <= 1'b1;
					zero_q  <= exp_y < Y_MIN;
					ip_q    <= 9'(exp_yc >>> 16);
					f_q     <= exp_yc[15:0];
					acc_q   <= 32'd1 << 30;
					cnt_q   <= '0;
					state_q <= (exp_y < Y_MIN) ? ST_EXP_FIN : ST_EXP;
				end
				ST_LERP: begin
					value_q <= up ? cur_q.lpt.lev + inc[16:0] : cur_q.lpt.lev - inc[16:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done  = (state_q == ST_DONE) && out_free;
	assign value = value_q;

endmodule

// ===== rtl/bent_breakpoint_curve_eval.sv =====
// ----------------------------------------------------------------------------
// bent_breakpoint_curve_eval
// Breakpoint table held in a row of cells; an evaluate word walks the row to
// find its segment, then a sequencer bends and interpolates.
//
//   channel | dir | payload
//   req     | in  | cmd, point_index, point_position, point_level, point_bend,
//           |     | point_hold, query_position
//   rsp     | out | curve_value
//   cfg     | in  | point_count
//
// An evaluate word walks the cell row (one cell per cycle), then the sequencer
// runs a 17-step divide, 16 log2 squarings and up to two 16-step exp2 runs.
// One evaluate word is in flight at a time; req.ready drops until its result
// sits in the output register, which holds while rsp.ready is low.
// Reset clears control state and the point count; the table is undefined.
// ----------------------------------------------------------------------------
module bent_breakpoint_curve_eval #(
	parameter int unsigned MAX_POINTS = bbc_pkg::MAX_POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bbc_req_if.sink   req,
	bbc_rsp_if.source rsp,
	bbc_cfg_if.sink   cfg
);

	logic [6:0]          count_q;
	logic                busy_q;
	logic                rsp_valid_q;
	logic [16:0]         rsp_value_q;
	logic                req_acc;
	logic                wr;
	logic                ev;
	logic                ev_done;
	logic [16:0]         ev_value;
	logic                out_free;
	bbc_pkg::bbc_point_t wr_pt;
	bbc_pkg::bbc_tok_t   tok_w [MAX_POINTS+1];
	bbc_pkg::bbc_point_t pt_w  [MAX_POINTS];

	assign req.ready = !busy_q;
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign wr        = req_acc && req.cmd == bbc_pkg::CMD_WRITE;
	assign ev        = req_acc && req.cmd == bbc_pkg::CMD_EVAL;
	assign out_free  = !rsp_valid_q || rsp.ready;

	always_comb begin
		wr_pt.pos  = req.point_position;
		wr_pt.lev  = (req.point_level > bbc_pkg::ONE_Q16) ? bbc_pkg::ONE_Q16
			: req.point_level;
		wr_pt.bend = req.point_bend;
		wr_pt.hold = req.point_hold;

		tok_w[0]       = '0;
		tok_w[0].valid = ev;
		tok_w[0].q     = req.query_position;
	end

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		bbc_pkg::bbc_cell_ctl_t ctl;
		bbc_pkg::bbc_point_t    prev;

		always_comb begin
			ctl.first = (i == 0);
			ctl.inr   = int'(count_q) > i;
			ctl.last  = (int'(count_q) == i + 1)
				|| (i == int'(MAX_POINTS) - 1 && int'(count_q) > i);
			ctl.wr_en = wr && int'(req.point_index) == i;
		end

		if (i == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = pt_w[i-1];
		end

		bbc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_pt   (wr_pt),
			.prev_pt (prev),
			.pt      (pt_w[i]),
			.tok_in  (tok_w[i]),
			.tok_out (tok_w[i+1])
		);
	end

	bbc_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (tok_w[MAX_POINTS]),
		.out_free (out_free),
		.done     (ev_done),
		.value    (ev_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) count_q <= cfg.point_count;
			if (ev)           busy_q <= 1'b1;
			else if (ev_done) busy_q <= 1'b0;
			if (ev_done)        rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_done) rsp_value_q <= ev_value;
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.curve_value = rsp_value_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ev_done |-> (!rsp_valid_q || rsp.ready))
		else $error("result register overwritten");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[MAX_POINTS].valid |-> busy_q)
		else $error("query word reached sequencer while idle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ev_done |-> busy_q)
		else $error("result produced with no evaluate word in flight");

endmodule
